// ===== src/fsds_pkg.sv =====
`default_nettype none
package fsds_pkg;

   // fixed field widths
   localparam int OP_W     = 3;
   localparam int ELEM_W   = 8;
   localparam int CARD_W   = 7;
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;
   localparam int POP_W    = 6;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_INCLUDE = 3'd1;
   localparam logic [OP_W-1:0] OP_EXCLUDE = 3'd2;
   localparam logic [OP_W-1:0] OP_NARROW  = 3'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BOUND,
      ST_CLOSE,
      ST_FILL,
      ST_DONE
   } state_type;

   // per-word result of the shared word unit
   typedef struct packed {
      logic             overlap;
      logic [POP_W-1:0] pop_in;
      logic [POP_W-1:0] pop_out;
   } word_stat_type;

endpackage
`default_nettype wire

// ===== src/fsds_if.sv =====
`default_nettype none
interface fsds_req_if;
   logic                                valid;
   logic                                ready;
   logic [fsds_pkg::OP_W-1:0]           operation;
   logic [fsds_pkg::ELEM_W-1:0]         element;
   logic [fsds_pkg::CARD_W-1:0]         card_low_req;
   logic [fsds_pkg::CARD_W-1:0]         card_high_req;

   modport source (output valid, output operation, output element,
                   output card_low_req, output card_high_req, input ready);
   modport sink   (input valid, input operation, input element,
                   input card_low_req, input card_high_req, output ready);
endinterface

interface fsds_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ok;
   logic                                failed;
   logic [fsds_pkg::CARD_W-1:0]         card_low;
   logic [fsds_pkg::CARD_W-1:0]         card_high;
   logic [fsds_pkg::CARD_W-1:0]         known_in;
   logic [fsds_pkg::CARD_W-1:0]         known_out;
   logic                                elem_is_in;
   logic                                elem_is_out;

   modport source (output valid, output ok, output failed, output card_low,
                   output card_high, output known_in, output known_out,
                   output elem_is_in, output elem_is_out, input ready);
   modport sink   (input valid, input ok, input failed, input card_low,
                   input card_high, input known_in, input known_out,
                   input elem_is_in, input elem_is_out, output ready);
endinterface
`default_nettype wire

// ===== src/fsds_word_unit.sv =====
`default_nettype none
module fsds_word_unit (
   input  wire logic [fsds_pkg::WORD_W-1:0] in_word,
   input  wire logic [fsds_pkg::WORD_W-1:0] out_word,
   output fsds_pkg::word_stat_type          stat
);

   logic [fsds_pkg::POP_W-1:0] pop_in;
   logic [fsds_pkg::POP_W-1:0] pop_out;

   // popcount of both mask words
   always_comb begin
      pop_in  = '0;
      pop_out = '0;
      for (int i = 0; i < fsds_pkg::WORD_W; i++) begin
         pop_in  = pop_in  + fsds_pkg::POP_W'(in_word[i]);
         pop_out = pop_out + fsds_pkg::POP_W'(out_word[i]);
      end
   end

   assign stat.overlap = |(in_word & out_word);
   assign stat.pop_in  = pop_in;
   assign stat.pop_out = pop_out;

endmodule
`default_nettype wire

// ===== src/finite_set_domain_store_top.sv =====
// states per beat: clear, query, out-of-range element or failed store go from idle to done;
// include, exclude, narrow go scan, bound, close, done, where a store that fails in bound skips
// close and a completed mask adds fill; done stalls while a result waits in the output register
// throughput: one beat at a time; the word unit walks the masks one 32-bit word per cycle
// the next beat is taken once the sequencer is back in idle, even while a result waits
// reset: synchronous, clears masks, counts, fail flag, bounds to 0..N and the sequencer
`default_nettype none
module finite_set_domain_store_top #(
   parameter int WORDS = 2
) (
   input wire logic    clock,
   input wire logic    reset,
   fsds_req_if.sink    req_if,
   fsds_rsp_if.source  rsp_if
);

   localparam int NELEM = fsds_pkg::WORD_W * WORDS;
   localparam int CW    = ($clog2(NELEM + 1) > fsds_pkg::CARD_W) ?
                          $clog2(NELEM + 1) : fsds_pkg::CARD_W;
   localparam int WI    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int EW1   = fsds_pkg::ELEM_W + 1;
   localparam logic [CW-1:0]  NELEM_C = CW'(NELEM);
   localparam logic [EW1-1:0] NELEM_E = EW1'(NELEM);
   localparam logic [WI-1:0]  LAST_W  = WI'(WORDS - 1);

   fsds_pkg::state_type state_ff, state_in;

   logic [fsds_pkg::WORD_W-1:0] in_mask_ff [WORDS];
   logic [fsds_pkg::WORD_W-1:0] in_mask_in [WORDS];
   logic [fsds_pkg::WORD_W-1:0] out_mask_ff [WORDS];
   logic [fsds_pkg::WORD_W-1:0] out_mask_in [WORDS];

   logic [CW-1:0] bound_low_ff, bound_low_in;
   logic [CW-1:0] bound_high_ff, bound_high_in;
   logic [CW-1:0] count_in_ff, count_in_in;
   logic [CW-1:0] count_out_ff, count_out_in;
   logic          fail_ff, fail_in;

   logic [WI-1:0] word_ff, word_in;
   logic [CW-1:0] acc_in_ff, acc_in_in;
   logic [CW-1:0] acc_out_ff, acc_out_in;
   logic          overlap_ff, overlap_in;
   logic          c1_ff, c1_in;
   logic          c2_ff, c2_in;
   logic          ok_ff, ok_in;
   logic          q_in_ff, q_in_in;
   logic          q_out_ff, q_out_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic                        rsp_failed_ff, rsp_failed_in;
   logic [fsds_pkg::CARD_W-1:0] rsp_low_ff, rsp_low_in;
   logic [fsds_pkg::CARD_W-1:0] rsp_high_ff, rsp_high_in;
   logic [fsds_pkg::CARD_W-1:0] rsp_kin_ff, rsp_kin_in;
   logic [fsds_pkg::CARD_W-1:0] rsp_kout_ff, rsp_kout_in;
   logic                        rsp_qin_ff, rsp_qin_in;
   logic                        rsp_qout_ff, rsp_qout_in;

   logic                          req_fire;
   logic                          in_range;
   logic [WI-1:0]                 e_word;
   logic [fsds_pkg::BIT_W-1:0]    e_bit;
   logic [WI-1:0]                 rd_idx;
   logic [fsds_pkg::WORD_W-1:0]   in_rd;
   logic [fsds_pkg::WORD_W-1:0]   out_rd;
   logic [fsds_pkg::WORD_W-1:0]   fill_out;
   logic [fsds_pkg::WORD_W-1:0]   fill_in;
   fsds_pkg::word_stat_type       stat;

   logic [CW-1:0] lo_req;
   logic [CW-1:0] hi_req;
   logic [CW-1:0] t_low;
   logic [CW-1:0] t_high;
   logic [CW-1:0] room;
   logic [CW-1:0] x_low;
   logic [CW-1:0] x_out;
   logic          x_c1;
   logic          x_c2;

   // element decode
   assign req_fire = req_if.valid && req_if.ready;
   assign in_range = ({1'b0, req_if.element} < NELEM_E);
   assign e_word   = WI'(req_if.element >> fsds_pkg::BIT_W);
   assign e_bit    = req_if.element[fsds_pkg::BIT_W-1:0];

   // single read port on the mask words
   assign rd_idx = (state_ff == fsds_pkg::ST_IDLE) ? e_word : word_ff;
   assign in_rd  = in_mask_ff[rd_idx];
   assign out_rd = out_mask_ff[rd_idx];

   fsds_word_unit u_word (
      .in_word  (in_rd),
      .out_word (out_rd),
      .stat     (stat)
   );

   // bound tightening terms
   assign lo_req = CW'(req_if.card_low_req);
   assign hi_req = CW'(req_if.card_high_req);
   assign t_low  = (acc_in_ff > bound_low_ff) ? acc_in_ff : bound_low_ff;
   assign room   = NELEM_C - acc_out_ff;
   assign t_high = (room < bound_high_ff) ? room : bound_high_ff;

   // completion terms
   assign x_c1  = (bound_high_ff == count_in_ff);
   assign x_low = x_c1 ? bound_high_ff : bound_low_ff;
   assign x_out = x_c1 ? (NELEM_C - count_in_ff) : count_out_ff;
   assign x_c2  = (x_low == (NELEM_C - x_out));

   // mask completion per word
   assign fill_out = c1_ff ? ~in_rd : out_rd;
   assign fill_in  = c2_ff ? ~fill_out : in_rd;

   assign req_if.ready = (state_ff == fsds_pkg::ST_IDLE);

   // sequencer: next state and register updates
   always_comb begin
      state_in      = state_ff;
      in_mask_in    = in_mask_ff;
      out_mask_in   = out_mask_ff;
      bound_low_in  = bound_low_ff;
      bound_high_in = bound_high_ff;
      count_in_in   = count_in_ff;
      count_out_in  = count_out_ff;
      fail_in       = fail_ff;
      word_in       = word_ff;
      acc_in_in     = acc_in_ff;
      acc_out_in    = acc_out_ff;
      overlap_in    = overlap_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      ok_in         = ok_ff;
      q_in_in       = q_in_ff;
      q_out_in      = q_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_kin_in    = rsp_kin_ff;
      rsp_kout_in   = rsp_kout_ff;
      rsp_qin_in    = rsp_qin_ff;
      rsp_qout_in   = rsp_qout_ff;

      case (state_ff)
         fsds_pkg::ST_IDLE: begin
            if (req_fire) begin
               q_in_in    = 1'b0;
               q_out_in   = 1'b0;
               word_in    = '0;
               acc_in_in  = '0;
               acc_out_in = '0;
               overlap_in = 1'b0;
               state_in   = fsds_pkg::ST_DONE;
               case (req_if.operation)
                  fsds_pkg::OP_CLEAR: begin
                     for (int k = 0; k < WORDS; k++) begin
                        in_mask_in[k]  = '0;
                        out_mask_in[k] = '0;
                     end
                     bound_low_in  = '0;
                     bound_high_in = NELEM_C;
                     count_in_in   = '0;
                     count_out_in  = '0;
                     fail_in       = 1'b0;
                     ok_in         = 1'b1;
                  end
                  fsds_pkg::OP_INCLUDE, fsds_pkg::OP_EXCLUDE: begin
                     if (!in_range) begin
                        ok_in = 1'b1;
                     end else if (fail_ff) begin
                        ok_in = 1'b0;
                     end else begin
                        if (req_if.operation == fsds_pkg::OP_INCLUDE) begin
                           in_mask_in[e_word][e_bit] = 1'b1;
                        end else begin
                           out_mask_in[e_word][e_bit] = 1'b1;
                        end
                        state_in = fsds_pkg::ST_SCAN;
                     end
                  end
                  fsds_pkg::OP_NARROW: begin
                     if (fail_ff) begin
                        ok_in = 1'b0;
                     end else begin
                        if (lo_req > bound_low_ff) begin
                           bound_low_in = lo_req;
                        end
                        if (hi_req < bound_high_ff) begin
                           bound_high_in = hi_req;
                        end
                        state_in = fsds_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     ok_in    = !fail_ff;
                     q_in_in  = in_range && in_rd[e_bit];
                     q_out_in = in_range && out_rd[e_bit];
                  end
               endcase
            end
         end

         // one word per cycle: overlap and popcounts
         fsds_pkg::ST_SCAN: begin
            overlap_in = overlap_ff || stat.overlap;
            acc_in_in  = acc_in_ff + CW'(stat.pop_in);
            acc_out_in = acc_out_ff + CW'(stat.pop_out);
            if (word_ff == LAST_W) begin
               word_in  = '0;
               state_in = fsds_pkg::ST_BOUND;
            end else begin
               word_in = word_ff + WI'(1);
            end
         end

         // overlap check, counts and tightened bounds
         fsds_pkg::ST_BOUND: begin
            if (overlap_ff) begin
               fail_in  = 1'b1;
               ok_in    = 1'b0;
               state_in = fsds_pkg::ST_DONE;
            end else begin
               count_in_in   = acc_in_ff;
               count_out_in  = acc_out_ff;
               bound_low_in  = t_low;
               bound_high_in = t_high;
               if (t_high < acc_in_ff || t_low > room || t_high < t_low) begin
                  fail_in  = 1'b1;
                  ok_in    = 1'b0;
                  state_in = fsds_pkg::ST_DONE;
               end else begin
                  state_in = fsds_pkg::ST_CLOSE;
               end
            end
         end

         // bounds meeting known counts
         fsds_pkg::ST_CLOSE: begin
            c1_in         = x_c1;
            c2_in         = x_c2;
            bound_low_in  = x_low;
            count_out_in  = x_out;
            count_in_in   = x_c2 ? x_low : count_in_ff;
            bound_high_in = x_c2 ? x_low : bound_high_ff;
            word_in       = '0;
            if (x_c1 || x_c2) begin
               state_in = fsds_pkg::ST_FILL;
            end else begin
               ok_in    = 1'b1;
               state_in = fsds_pkg::ST_DONE;
            end
         end

         // complete the opposite mask word by word
         fsds_pkg::ST_FILL: begin
            in_mask_in[word_ff]  = fill_in;
            out_mask_in[word_ff] = fill_out;
            if (word_ff == LAST_W) begin
               word_in  = '0;
               ok_in    = 1'b1;
               state_in = fsds_pkg::ST_DONE;
            end else begin
               word_in = word_ff + WI'(1);
            end
         end

         // load the output register once it is free
         fsds_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = ok_ff;
               rsp_failed_in = fail_ff;
               rsp_low_in    = bound_low_ff[fsds_pkg::CARD_W-1:0];
               rsp_high_in   = bound_high_ff[fsds_pkg::CARD_W-1:0];
               rsp_kin_in    = count_in_ff[fsds_pkg::CARD_W-1:0];
               rsp_kout_in   = count_out_ff[fsds_pkg::CARD_W-1:0];
               rsp_qin_in    = q_in_ff;
               rsp_qout_in   = q_out_ff;
               state_in      = fsds_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fsds_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // store and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WORDS; k++) begin
            in_mask_ff[k]  <= '0;
            out_mask_ff[k] <= '0;
         end
         bound_low_ff  <= '0;
         bound_high_ff <= NELEM_C;
         count_in_ff   <= '0;
         count_out_ff  <= '0;
         fail_ff       <= 1'b0;
         word_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_mask_ff    <= in_mask_in;
         out_mask_ff   <= out_mask_in;
         bound_low_ff  <= bound_low_in;
         bound_high_ff <= bound_high_in;
         count_in_ff   <= count_in_in;
         count_out_ff  <= count_out_in;
         fail_ff       <= fail_in;
         word_ff       <= word_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      acc_in_ff     <= acc_in_in;
      acc_out_ff    <= acc_out_in;
      overlap_ff    <= overlap_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      ok_ff         <= ok_in;
      q_in_ff       <= q_in_in;
      q_out_ff      <= q_out_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_kin_ff    <= rsp_kin_in;
      rsp_kout_ff   <= rsp_kout_in;
      rsp_qin_ff    <= rsp_qin_in;
      rsp_qout_ff   <= rsp_qout_in;
   end

   // result channel
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.ok          = rsp_ok_ff;
   assign rsp_if.failed      = rsp_failed_ff;
   assign rsp_if.card_low    = rsp_low_ff;
   assign rsp_if.card_high   = rsp_high_ff;
   assign rsp_if.known_in    = rsp_kin_ff;
   assign rsp_if.known_out   = rsp_kout_ff;
   assign rsp_if.elem_is_in  = rsp_qin_ff;
   assign rsp_if.elem_is_out = rsp_qout_ff;

endmodule
`default_nettype wire

// ===== sim/fsds_store_checker.sv =====
`timescale 1ns / 100ps
module fsds_store_checker #(
   parameter int WORDS = 2
) (
   input  logic clock,
   input  logic reset,
   fsds_req_if  req_if,
   fsds_rsp_if  rsp_if,
   output int   mismatch_count,
   output int   outstanding
);

   localparam int NELEM        = 32 * WORDS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                        ok;
      logic                        failed;
      logic [fsds_pkg::CARD_W-1:0] card_low;
      logic [fsds_pkg::CARD_W-1:0] card_high;
      logic [fsds_pkg::CARD_W-1:0] known_in;
      logic [fsds_pkg::CARD_W-1:0] known_out;
      logic                        elem_is_in;
      logic                        elem_is_out;
   } store_status_type;

   // shadow copy of the domain store
   logic [NELEM-1:0] in_bits;
   logic [NELEM-1:0] out_bits;
   int unsigned      lo_bound;
   int unsigned      hi_bound;
   int unsigned      n_in;
   int unsigned      n_out;
   logic             failed_q;

   // predicted status beats, oldest first
   store_status_type status_q[$];

   function automatic void clear_store();
      in_bits  = '0;
      out_bits = '0;
      lo_bound = 0;
      hi_bound = NELEM;
      n_in     = 0;
      n_out    = 0;
      failed_q = 1'b0;
   endfunction

   // recount both masks, tighten the bounds, detect failure, complete a mask
   function automatic logic tighten_store();
      int unsigned room;
      if ((in_bits & out_bits) != '0) begin
         failed_q = 1'b1;
         return 1'b0;
      end
      n_in  = $countones(in_bits);
      n_out = $countones(out_bits);
      if (n_in > lo_bound) lo_bound = n_in;
      room = NELEM - n_out;
      if (room < hi_bound) hi_bound = room;
      if (hi_bound < n_in || lo_bound > room || hi_bound < lo_bound) begin
         failed_q = 1'b1;
         return 1'b0;
      end
      // upper bound reached by the known members: everything else is out
      if (hi_bound == n_in) begin
         lo_bound = hi_bound;
         n_out    = NELEM - n_in;
         out_bits = ~in_bits;
      end
      // lower bound needs every element not known out
      if (lo_bound == NELEM - n_out) begin
         n_in     = lo_bound;
         hi_bound = lo_bound;
         in_bits  = ~out_bits;
      end
      return 1'b1;
   endfunction

   // apply one operation to the shadow store and build the status it reports
   function automatic store_status_type apply_store_op(
      input logic [fsds_pkg::OP_W-1:0]   op,
      input logic [fsds_pkg::ELEM_W-1:0] elem,
      input logic [fsds_pkg::CARD_W-1:0] lo_req,
      input logic [fsds_pkg::CARD_W-1:0] hi_req);
      store_status_type s;
      logic             ok;
      logic             q_in;
      logic             q_out;
      ok    = 1'b0;
      q_in  = 1'b0;
      q_out = 1'b0;
      case (op)
         fsds_pkg::OP_CLEAR: begin
            clear_store();
            ok = 1'b1;
         end
         fsds_pkg::OP_INCLUDE, fsds_pkg::OP_EXCLUDE: begin
            // out-of-range element is a no-op that reports ok, failed or not
            if (elem >= NELEM) begin
               ok = 1'b1;
            end else if (!failed_q) begin
               if (op == fsds_pkg::OP_INCLUDE) in_bits[elem] = 1'b1;
               else out_bits[elem] = 1'b1;
               ok = tighten_store();
            end
         end
         fsds_pkg::OP_NARROW: begin
            if (!failed_q) begin
               if (lo_req > lo_bound) lo_bound = lo_req;
               if (hi_req < hi_bound) hi_bound = hi_req;
               ok = tighten_store();
            end
         end
         default: begin
            // query, including the unused codes
            ok = !failed_q;
            if (elem < NELEM) begin
               q_in  = in_bits[elem];
               q_out = out_bits[elem];
            end
         end
      endcase
      s.ok          = ok;
      s.failed      = failed_q;
      s.card_low    = lo_bound[fsds_pkg::CARD_W-1:0];
      s.card_high   = hi_bound[fsds_pkg::CARD_W-1:0];
      s.known_in    = n_in[fsds_pkg::CARD_W-1:0];
      s.known_out   = n_out[fsds_pkg::CARD_W-1:0];
      s.elem_is_in  = q_in;
      s.elem_is_out = q_out;
      return s;
   endfunction

   function automatic string status_text(input store_status_type s);
      return $sformatf("ok=%0d failed=%0d low=%0d high=%0d in=%0d out=%0d is_in=%0d is_out=%0d",
                       s.ok, s.failed, s.card_low, s.card_high, s.known_in, s.known_out,
                       s.elem_is_in, s.elem_is_out);
   endfunction

   // compare result beats first, then predict from the request beat
   always @(posedge clock) begin : watch
      store_status_type seen;
      store_status_type want;
      if (reset) begin
         clear_store();
         status_q.delete();
         mismatch_count = 0;
         outstanding    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.ok          = rsp_if.ok;
            seen.failed      = rsp_if.failed;
            seen.card_low    = rsp_if.card_low;
            seen.card_high   = rsp_if.card_high;
            seen.known_in    = rsp_if.known_in;
            seen.known_out   = rsp_if.known_out;
            seen.elem_is_in  = rsp_if.elem_is_in;
            seen.elem_is_out = rsp_if.elem_is_out;
            if (status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("checker: unexpected result beat: %s", status_text(seen));
            end else begin
               want = status_q.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("checker: result mismatch");
                     $display("   expected %s", status_text(want));
                     $display("   actual   %s", status_text(seen));
                  end
               end
            end
         end
         if (req_if.valid && req_if.ready)
            status_q.push_back(apply_store_op(req_if.operation, req_if.element,
                                              req_if.card_low_req, req_if.card_high_req));
         outstanding = status_q.size();
      end
   end

endmodule

// ===== sim/tb_finite_set_domain_store_top.sv =====
`timescale 1ns / 100ps
module tb_finite_set_domain_store_top;

   localparam int WORDS        = 2;
   localparam int NELEM        = 32 * WORDS;
   localparam int ELEM_MAX     = 2 ** fsds_pkg::ELEM_W - 1;
   localparam int CARD_MAX     = 2 ** fsds_pkg::CARD_W - 1;
   localparam int RANDOM_ITEMS = 500;
   localparam int MAX_GAP      = 4;
   localparam int HOLD_START   = 1000;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 100000;

   localparam logic [fsds_pkg::OP_W-1:0] OP_QUERY    = 3'd4;
   localparam logic [fsds_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [fsds_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic clock;
   logic reset;
   logic hold_rsp;
   bit   sender_calm;
   int   cycle_count;
   int   mismatch_count;
   int   outstanding;

   fsds_req_if req_if();
   fsds_rsp_if rsp_if();

   finite_set_domain_store_top #(
      .WORDS(WORDS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   fsds_store_checker #(
      .WORDS(WORDS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // long receiver hold-off so the block fills up and stalls its input
   initial begin
      hold_rsp = 1'b0;
      repeat (HOLD_START) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // result side: random stalls, calm stretches, the long hold-off
   initial begin : rsp_drain
      int gap;
      int beats;
      bit calm;
      beats = 0;
      calm  = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (beats % 30 == 0) calm = ($urandom_range(2) == 0);
         gap = calm ? 0 : $urandom_range(MAX_GAP);
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         while (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         beats++;
      end
   end

   // offer one request beat after a random gap and wait for it to be taken
   task automatic send_beat(input logic [fsds_pkg::OP_W-1:0] op,
                            input int                        elem,
                            input int                        lo,
                            input int                        hi);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(MAX_GAP);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.operation     <= op;
      req_if.element       <= fsds_pkg::ELEM_W'(elem);
      req_if.card_low_req  <= fsds_pkg::CARD_W'(lo);
      req_if.card_high_req <= fsds_pkg::CARD_W'(hi);
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // cardinality near zero, near the set size, or anywhere in the field
   function automatic int pick_card();
      case ($urandom_range(2))
         0:       return $urandom_range(6);
         1:       return $urandom_range(NELEM, NELEM - 6);
         default: return $urandom_range(CARD_MAX);
      endcase
   endfunction

   // request side
   initial begin : stimulus
      logic [fsds_pkg::OP_W-1:0] op;
      int                        elem;
      int                        lo;
      int                        hi;
      int                        pick;
      int                        items_sent;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.operation     <= fsds_pkg::OP_CLEAR;
      req_if.element       <= '0;
      req_if.card_low_req  <= '0;
      req_if.card_high_req <= '0;
      sender_calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, range edges, completion and failure paths
      send_beat(OP_QUERY,             0,         0,        0);
      send_beat(fsds_pkg::OP_INCLUDE, 0,         0,        0);
      send_beat(fsds_pkg::OP_INCLUDE, NELEM - 1, 0,        0);
      send_beat(fsds_pkg::OP_EXCLUDE, 1,         0,        0);
      send_beat(fsds_pkg::OP_INCLUDE, NELEM,     0,        0);
      send_beat(fsds_pkg::OP_EXCLUDE, ELEM_MAX,  0,        0);
      send_beat(OP_SPARE_LO,          NELEM - 1, 0,        0);
      send_beat(OP_SPARE_HI,          ELEM_MAX,  0,        0);
      send_beat(fsds_pkg::OP_NARROW,  0,         0,        CARD_MAX);
      // upper bound meets the known members: the rest goes out
      send_beat(fsds_pkg::OP_NARROW,  0,         2,        2);
      send_beat(OP_QUERY,             1,         0,        0);
      // include of an element already out: overlap
      send_beat(fsds_pkg::OP_INCLUDE, 1,         0,        0);
      send_beat(fsds_pkg::OP_INCLUDE, 5,         0,        0);
      send_beat(fsds_pkg::OP_INCLUDE, 200,       0,        0);
      send_beat(fsds_pkg::OP_NARROW,  0,         0,        10);
      send_beat(OP_QUERY,             0,         0,        0);
      send_beat(fsds_pkg::OP_CLEAR,   0,         0,        0);
      // empty bounds
      send_beat(fsds_pkg::OP_NARROW,  0,         CARD_MAX, 0);
      send_beat(fsds_pkg::OP_CLEAR,   0,         0,        0);
      // lower bound at the set size: everything comes in
      send_beat(fsds_pkg::OP_NARROW,  0,         NELEM,    NELEM);
      send_beat(OP_QUERY,             5,         0,        0);
      send_beat(fsds_pkg::OP_EXCLUDE, 5,         0,        0);
      send_beat(fsds_pkg::OP_CLEAR,   0,         0,        0);
      send_beat(fsds_pkg::OP_EXCLUDE, 3,         0,        0);
      send_beat(fsds_pkg::OP_NARROW,  0,         0,        0);

      // random: short episodes that start from a cleared store
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         sender_calm = ($urandom_range(3) == 0);
         send_beat(fsds_pkg::OP_CLEAR, $urandom_range(ELEM_MAX), pick_card(), pick_card());
         items_sent++;
         repeat ($urandom_range(30, 4)) begin
            pick = $urandom_range(99);
            if (pick < 2) op = fsds_pkg::OP_CLEAR;
            else if (pick < 33) op = fsds_pkg::OP_INCLUDE;
            else if (pick < 60) op = fsds_pkg::OP_EXCLUDE;
            else if (pick < 74) op = fsds_pkg::OP_NARROW;
            else if (pick < 93) op = OP_QUERY;
            else op = fsds_pkg::OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            // mostly in-range elements, some anywhere in the field
            if ($urandom_range(9) == 0) elem = $urandom_range(ELEM_MAX);
            else elem = $urandom_range(NELEM - 1);
            lo = ($urandom_range(1) == 0) ? 0 : pick_card();
            hi = ($urandom_range(1) == 0) ? CARD_MAX : pick_card();
            send_beat(op, elem, lo, hi);
            items_sent++;
         end
      end
      req_if.valid <= 1'b0;

      // drain the outstanding results, then allow for late extra beats
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
